>>> hdl/tse_pkg.sv
`timescale 1ns / 1ps

package tse_pkg;

  // Width of the payload length counter; long-form lengths keep their low 32 bits.
  localparam int unsigned PayloadW = 32;

  // Tag value after reset.
  localparam logic [7:0] TagReset = 8'd26;

  // Short-form limit and long-form marker of the first length byte.
  localparam logic [7:0] LongFormBit = 8'h80;

  // Decoder phases, one-hot.
  typedef enum logic [5:0] {
    PH_SEARCH    = 6'b000001,
    PH_LEN_FIRST = 6'b000010,
    PH_LEN_MORE  = 6'b000100,
    PH_PAYLOAD   = 6'b001000,
    PH_DONE      = 6'b010000,
    PH_BAD       = 6'b100000
  } phase_t;

  // Status reported with each result beat.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_NO_TAG    = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       last;
    status_t    status;
  } result_t;

endpackage

>>> hdl/tagged_string_extractor.sv
`timescale 1ns / 1ps

// Channel   Direction  Contents
// in_*      slave      tdata = data_byte, tlast = record_end
// out_*     master     tdata = text_byte, tuser = {status, has_byte}, tlast = last
// cfg_*     APB        register 0 at byte address 0: tag_value (8 bits)
//
// The decoder state and the result are updated at the edge that accepts an input
// byte; the result goes to the output register, or to the skid entry while out_* stalls.
// A byte is accepted in every cycle while the output side keeps up; one skid entry
// behind the output register absorbs a single stalled result before in_tready drops.
// Reset (rst_n low, synchronous) restores tag_value to 26, clears the decoder state
// and empties both output stages; no clearing pass is needed.
module tagged_string_extractor #(
  parameter int unsigned MAX_LEN_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] data_byte
  input  logic       in_tlast,
  // Result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] text_byte
  output logic [2:0] out_tuser,    // [0] has_byte, [2:1] status
  output logic       out_tlast,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned LblW = $clog2(MAX_LEN_BYTES + 1);
  localparam logic [6:0] MaxLenCnt = 7'(MAX_LEN_BYTES);
  localparam logic [LblW-1:0] LblOne = LblW'(1);
  localparam logic [tse_pkg::PayloadW-1:0] PayOne = tse_pkg::PayloadW'(1);

  logic [7:0]                    tag_r;
  tse_pkg::phase_t               phase_r, phase_nxt;
  logic [LblW-1:0]               lbl_r, lbl_nxt;
  logic [tse_pkg::PayloadW-1:0]  pay_r, pay_nxt;

  logic                          out_valid_r, out_valid_nxt;
  tse_pkg::result_t              out_r, out_nxt;
  logic                          skid_valid_r, skid_valid_nxt;
  tse_pkg::result_t              skid_r, skid_nxt;

  logic                          in_beat;
  logic                          emit;
  tse_pkg::result_t              res;
  logic                          cfg_wr;

  // Configuration register access.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {24'd0, tag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= tse_pkg::TagReset;
    end else if (cfg_wr) begin
      tag_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_beat   = in_tvalid && in_tready;

  // Decoder step for one input byte.
  always_comb begin
    logic       len_done;
    logic [6:0] cnt;
    logic [tse_pkg::PayloadW-1:0] pay_dec;
    len_done      = 1'b0;
    cnt           = in_tdata[6:0];
    pay_dec       = pay_r - PayOne;
    phase_nxt     = phase_r;
    lbl_nxt       = lbl_r;
    pay_nxt       = pay_r;
    emit          = 1'b0;
    res.text_byte = 8'd0;
    res.has_byte  = 1'b0;
    res.last      = 1'b0;
    res.status    = tse_pkg::ST_OK;

    unique case (phase_r)
      tse_pkg::PH_SEARCH: begin
        if (in_tdata == tag_r) begin
          phase_nxt = tse_pkg::PH_LEN_FIRST;
        end
      end
      tse_pkg::PH_LEN_FIRST: begin
        if (in_tdata < tse_pkg::LongFormBit) begin
          pay_nxt  = tse_pkg::PayloadW'(in_tdata);
          len_done = 1'b1;
        end else if (cnt == 7'd0 || cnt > MaxLenCnt) begin
          phase_nxt = tse_pkg::PH_BAD;
        end else begin
          lbl_nxt   = LblW'(cnt);
          pay_nxt   = '0;
          phase_nxt = tse_pkg::PH_LEN_MORE;
        end
      end
      tse_pkg::PH_LEN_MORE: begin
        // Big-endian accumulation of the long-form length.
        pay_nxt = {pay_r[tse_pkg::PayloadW-9:0], in_tdata};
        lbl_nxt = lbl_r - LblOne;
        if (lbl_r == LblOne) begin
          len_done = 1'b1;
        end
      end
      tse_pkg::PH_PAYLOAD: begin
        emit          = 1'b1;
        res.has_byte  = 1'b1;
        res.text_byte = in_tdata;
        pay_nxt       = pay_dec;
        if (pay_r == PayOne) begin
          res.last  = 1'b1;
          phase_nxt = tse_pkg::PH_DONE;
        end
      end
      tse_pkg::PH_DONE, tse_pkg::PH_BAD: begin
      end
      default: begin
      end
    endcase

    // Length complete: a zero length closes the string at once.
    if (len_done) begin
      if (pay_nxt == '0) begin
        emit      = 1'b1;
        res.last  = 1'b1;
        phase_nxt = tse_pkg::PH_DONE;
      end else begin
        phase_nxt = tse_pkg::PH_PAYLOAD;
      end
    end

    // End of record: report what is still open, then start over.
    if (in_tlast) begin
      if (!(emit && res.last)) begin
        unique case (phase_nxt)
          tse_pkg::PH_SEARCH: begin
            emit       = 1'b1;
            res.last   = 1'b1;
            res.status = tse_pkg::ST_NO_TAG;
          end
          tse_pkg::PH_LEN_FIRST, tse_pkg::PH_LEN_MORE, tse_pkg::PH_PAYLOAD: begin
            emit       = 1'b1;
            res.last   = 1'b1;
            res.status = tse_pkg::ST_TRUNCATED;
          end
          tse_pkg::PH_BAD: begin
            emit       = 1'b1;
            res.last   = 1'b1;
            res.status = tse_pkg::ST_BAD_LEN;
          end
          default: begin
          end
        endcase
      end
      phase_nxt = tse_pkg::PH_SEARCH;
      lbl_nxt   = '0;
      pay_nxt   = '0;
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tse_pkg::PH_SEARCH;
      lbl_r   <= '0;
      pay_r   <= '0;
    end else if (in_beat) begin
      phase_r <= phase_nxt;
      lbl_r   <= lbl_nxt;
      pay_r   <= pay_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_valid_r && !out_tready) begin
      if (in_beat && emit) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = in_beat && emit;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.text_byte;
  assign out_tuser  = {out_r.status, out_r.has_byte};
  assign out_tlast  = out_r.last;

  // The skid entry only fills behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A beat without a payload byte always closes the record.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.has_byte) |-> out_r.last)
    else $error("result without payload byte is not marked last");

  // Any error status closes the record.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != tse_pkg::ST_OK) |-> out_r.last)
    else $error("error status on a beat that is not last");

  // The payload phase is only ever held with bytes still owed.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tse_pkg::PH_PAYLOAD) |-> (pay_r != '0))
    else $error("payload phase with zero bytes left");

endmodule
